>>> sv/vefc_pkg.sv
`timescale 1ns / 1ps

package vefc_pkg;

  // Field and register widths
  localparam int VALUE_W  = 32;
  localparam int CNT_W    = 48;
  localparam int COUNT_W  = 32;
  localparam int RATE_W   = 16;
  localparam int MODE_W   = 2;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 32;
  localparam int DEF_FRACTION_BITS = 16;

  // Queue between front and back
  localparam int QUEUE_DEPTH = 2;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_COUNT_MODE  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_RESET_VALUE = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SAMPLE_RATE = 2'd2;

  // Counting modes
  localparam logic [MODE_W-1:0] MODE_RISE = 2'd0;
  localparam logic [MODE_W-1:0] MODE_FALL = 2'd1;
  localparam logic [MODE_W-1:0] MODE_PASS = 2'd2;
  localparam logic [MODE_W-1:0] MODE_FREQ = 2'd3;

  // Reset values of the registers
  localparam logic [MODE_W-1:0]     RST_COUNT_MODE  = MODE_RISE;
  localparam logic [VALUE_W-1:0]    RST_RESET_VALUE = '0;
  localparam logic [RATE_W-1:0]     RST_SAMPLE_RATE = 16'd256;

  // Operation handed from front to back
  typedef enum logic [2:0] {
    OP_NONE,
    OP_LOAD,
    OP_BUMP,
    OP_PASS,
    OP_FREQ
  } op_kind_t;

  typedef struct packed {
    op_kind_t             kind;
    logic                 flag;   // sample validity for pass-through
    logic [VALUE_W-1:0]   value;  // sample value for pass-through
    logic [COUNT_W-1:0]   den;    // sample count for a frequency edge
  } op_t;

endpackage

>>> sv/vefc_front.sv
`timescale 1ns / 1ps

module vefc_front (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic [vefc_pkg::MODE_W-1:0]    count_mode,
  input  logic                           take,
  input  logic                           is_reset,
  input  logic                           cur_valid,
  input  logic [vefc_pkg::VALUE_W-1:0]   value,
  output vefc_pkg::op_t                  op
);

  logic                           prev_valid_r, prev_valid_nxt;
  logic [vefc_pkg::COUNT_W-1:0]   samples_r, samples_nxt;
  logic [vefc_pkg::COUNT_W-1:0]   samples_inc;
  logic                           rise, fall;

  // Saturating sample count and edge detection
  assign samples_inc = (samples_r == {vefc_pkg::COUNT_W{1'b1}}) ? samples_r
                                                               : samples_r + 1'b1;
  assign rise = !prev_valid_r && cur_valid;
  assign fall = prev_valid_r && !cur_valid;

  // Classify the item
  always_comb begin
    op.kind        = vefc_pkg::OP_NONE;
    op.flag        = cur_valid;
    op.value       = value;
    op.den         = samples_inc;
    prev_valid_nxt = prev_valid_r;
    samples_nxt    = samples_r;
    if (is_reset) begin
      if (cur_valid) begin
        op.kind = vefc_pkg::OP_LOAD;
      end
    end else begin
      prev_valid_nxt = cur_valid;
      samples_nxt    = samples_inc;
      case (count_mode)
        vefc_pkg::MODE_RISE: begin
          if (rise) op.kind = vefc_pkg::OP_BUMP;
        end
        vefc_pkg::MODE_FALL: begin
          if (fall) op.kind = vefc_pkg::OP_BUMP;
        end
        vefc_pkg::MODE_PASS: begin
          op.kind = vefc_pkg::OP_PASS;
        end
        vefc_pkg::MODE_FREQ: begin
          if (rise) begin
            op.kind     = vefc_pkg::OP_FREQ;
            samples_nxt = '0;
          end
        end
        default: begin
          op.kind = vefc_pkg::OP_NONE;
        end
      endcase
    end
  end

  // Track sample history on accepted items
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_valid_r <= 1'b0;
      samples_r    <= '0;
    end else if (take) begin
      prev_valid_r <= prev_valid_nxt;
      samples_r    <= samples_nxt;
    end
  end

endmodule

>>> sv/vefc_queue.sv
`timescale 1ns / 1ps

module vefc_queue (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  vefc_pkg::op_t  push_op,
  output logic           full,
  input  logic           pop,
  output logic           empty,
  output vefc_pkg::op_t  head_op
);

  localparam int DEPTH = vefc_pkg::QUEUE_DEPTH;
  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST = PTR_W'(DEPTH - 1);

  vefc_pkg::op_t     entry_r [DEPTH];
  logic [PTR_W-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0]  fill_r, fill_nxt;
  logic              do_push, do_pop;

  assign full    = (fill_r == CNT_W'(DEPTH));
  assign empty   = (fill_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign head_op = entry_r[rd_ptr_r];

  // Advance pointers and fill level
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    fill_nxt   = fill_r;
    if (do_push) wr_ptr_nxt = (wr_ptr_r == LAST) ? '0 : wr_ptr_r + 1'b1;
    if (do_pop)  rd_ptr_nxt = (rd_ptr_r == LAST) ? '0 : rd_ptr_r + 1'b1;
    if (do_push && !do_pop) fill_nxt = fill_r + 1'b1;
    else if (!do_push && do_pop) fill_nxt = fill_r - 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      fill_r   <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      fill_r   <= fill_nxt;
    end
  end

  // Store pushed operations
  always_ff @(posedge clk) begin
    if (do_push) entry_r[wr_ptr_r] <= push_op;
  end

endmodule

>>> sv/vefc_back.sv
`timescale 1ns / 1ps

module vefc_back #(
  parameter int FRACTION_BITS = vefc_pkg::DEF_FRACTION_BITS
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic [vefc_pkg::VALUE_W-1:0]    reset_value,
  input  logic [vefc_pkg::RATE_W-1:0]     sample_rate,
  input  logic                            op_empty,
  input  vefc_pkg::op_t                   op,
  output logic                            op_pop,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [vefc_pkg::CNT_W-1:0]      out_counter,
  output logic                            out_counter_valid
);

  localparam int CNT_W  = vefc_pkg::CNT_W;
  localparam int VAL_W  = vefc_pkg::VALUE_W;
  localparam int DEN_W  = vefc_pkg::COUNT_W;
  localparam int NUM_W  = vefc_pkg::RATE_W + FRACTION_BITS;
  localparam int STEP_W = $clog2(NUM_W + 1);
  localparam logic signed [CNT_W-1:0] UNIT    = CNT_W'(1) << FRACTION_BITS;
  localparam logic signed [CNT_W-1:0] CNT_MAX = {1'b0, {(CNT_W-1){1'b1}}};

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_DONE
  } state_t;

  state_t                    state_r;
  logic signed [CNT_W-1:0]   cnt_r;
  logic                      cnt_valid_r;
  logic                      out_valid_r;
  logic [CNT_W-1:0]          out_cnt_r;
  logic                      out_cv_r;
  logic [DEN_W-1:0]          rem_r;
  logic [DEN_W-1:0]          den_r;
  logic [NUM_W-1:0]          quo_r;
  logic [STEP_W-1:0]         step_r;

  logic                      slot_free;
  logic                      out_load;
  logic signed [CNT_W-1:0]   cnt_base, cnt_bump, cnt_imm;
  logic                      cv_imm;
  logic [DEN_W:0]            rem_sh, rem_diff;
  logic                      rem_ge;

  assign slot_free = !out_valid_r || out_ready;
  assign op_pop    = (state_r == ST_IDLE) && !op_empty && slot_free;
  assign out_load  = (op_pop && (op.kind != vefc_pkg::OP_FREQ)) ||
                     ((state_r == ST_DONE) && slot_free);

  // Saturating edge increment; an invalid counter starts from zero
  assign cnt_base = cnt_valid_r ? cnt_r : '0;
  assign cnt_bump = (cnt_base > CNT_MAX - UNIT) ? CNT_MAX : cnt_base + UNIT;

  // Result of a load, edge increment or pass-through operation
  always_comb begin
    cnt_imm = cnt_r;
    cv_imm  = cnt_valid_r;
    case (op.kind)
      vefc_pkg::OP_LOAD: begin
        cnt_imm = {{(CNT_W-VAL_W){reset_value[VAL_W-1]}}, reset_value};
        cv_imm  = 1'b1;
      end
      vefc_pkg::OP_BUMP: begin
        cnt_imm = cnt_bump;
        cv_imm  = 1'b1;
      end
      vefc_pkg::OP_PASS: begin
        cnt_imm = op.flag ? {{(CNT_W-VAL_W){op.value[VAL_W-1]}}, op.value} : '0;
        cv_imm  = op.flag;
      end
      default: begin
        cnt_imm = cnt_r;
        cv_imm  = cnt_valid_r;
      end
    endcase
  end

  // One restoring divide step
  assign rem_sh   = {rem_r, quo_r[NUM_W-1]};
  assign rem_ge   = rem_sh >= {1'b0, den_r};
  assign rem_diff = rem_sh - {1'b0, den_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= '0;
      cnt_valid_r <= 1'b1;
      out_valid_r <= 1'b0;
    end else begin
      // Raise on a new result, drop once it is taken
      if (out_load) out_valid_r <= 1'b1;
      else if (out_ready) out_valid_r <= 1'b0;
      case (state_r)
        ST_IDLE: begin
          if (op_pop) begin
            if (op.kind == vefc_pkg::OP_FREQ) begin
              state_r <= ST_DIV;
            end else begin
              cnt_r       <= cnt_imm;
              cnt_valid_r <= cv_imm;
              out_cnt_r   <= cv_imm ? cnt_imm : '0;
              out_cv_r    <= cv_imm;
            end
          end
        end
        ST_DIV: begin
          if (step_r == STEP_W'(1)) state_r <= ST_DONE;
        end
        ST_DONE: begin
          if (slot_free) begin
            cnt_r       <= {{(CNT_W-NUM_W){1'b0}}, quo_r};
            cnt_valid_r <= 1'b1;
            out_cnt_r   <= {{(CNT_W-NUM_W){1'b0}}, quo_r};
            out_cv_r    <= 1'b1;
            state_r     <= ST_IDLE;
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

  // Divider datapath: load on a frequency edge, then shift one bit a cycle
  always_ff @(posedge clk) begin
    if (op_pop && op.kind == vefc_pkg::OP_FREQ) begin
      rem_r  <= '0;
      den_r  <= op.den;
      quo_r  <= {sample_rate, {FRACTION_BITS{1'b0}}};
      step_r <= STEP_W'(NUM_W);
    end else if (state_r == ST_DIV) begin
      rem_r  <= rem_ge ? rem_diff[DEN_W-1:0] : rem_sh[DEN_W-1:0];
      quo_r  <= {quo_r[NUM_W-2:0], rem_ge};
      step_r <= step_r - 1'b1;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_counter       = out_cnt_r;
  assign out_counter_valid = out_cv_r;

endmodule

>>> sv/validity_edge_and_frequency_counter.sv
`timescale 1ns / 1ps

// Channel  Dir  Handshake              Payload
// in       in   in_tvalid/in_tready    tdata: value; tuser: action, value_valid
// out      out  out_tvalid/out_tready  tdata: counter_value; tuser: counter_valid
// cfg      in   cfg_we                 cfg_index, cfg_data
//
// Every item gives one result. Loads, edge increments and pass-through are
// done as soon as they are popped; a frequency edge goes through the
// one-bit-per-cycle restoring divider, and no new item is popped until its
// result is loaded. A two-entry queue sits between the classifying front
// end and the back end, and the back end takes no new item while a result
// waits in the output register. Reset (rst_n low, synchronous) clears the
// queue, edge history, sample count and counter; no clearing pass is needed.

module validity_edge_and_frequency_counter #(
  parameter int FRACTION_BITS = vefc_pkg::DEF_FRACTION_BITS
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  input  logic [vefc_pkg::VALUE_W-1:0]      in_tdata,   // [31:0] value
  input  logic [1:0]                        in_tuser,   // [0] action, [1] value_valid
  output logic                              out_tvalid,
  input  logic                              out_tready,
  output logic [vefc_pkg::CNT_W-1:0]        out_tdata,  // [47:0] counter_value
  output logic                              out_tuser,  // [0] counter_valid
  input  logic                              cfg_we,
  input  logic [vefc_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [vefc_pkg::CFG_DATA_W-1:0]   cfg_data
);

  logic [vefc_pkg::MODE_W-1:0]   count_mode_r;
  logic [vefc_pkg::VALUE_W-1:0]  reset_value_r;
  logic [vefc_pkg::RATE_W-1:0]   sample_rate_r;

  vefc_pkg::op_t  front_op;
  vefc_pkg::op_t  head_op;
  logic           q_full, q_empty, q_pop, take;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_mode_r  <= vefc_pkg::RST_COUNT_MODE;
      reset_value_r <= vefc_pkg::RST_RESET_VALUE;
      sample_rate_r <= vefc_pkg::RST_SAMPLE_RATE;
    end else if (cfg_we) begin
      case (cfg_index)
        vefc_pkg::REG_COUNT_MODE:  count_mode_r  <= cfg_data[vefc_pkg::MODE_W-1:0];
        vefc_pkg::REG_RESET_VALUE: reset_value_r <= cfg_data[vefc_pkg::VALUE_W-1:0];
        vefc_pkg::REG_SAMPLE_RATE: sample_rate_r <= cfg_data[vefc_pkg::RATE_W-1:0];
        default: begin
        end
      endcase
    end
  end

  assign in_tready = !q_full;
  assign take      = in_tvalid && !q_full;

  vefc_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .count_mode (count_mode_r),
    .take       (take),
    .is_reset   (in_tuser[0]),
    .cur_valid  (in_tuser[1]),
    .value      (in_tdata),
    .op         (front_op)
  );

  vefc_queue u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (take),
    .push_op (front_op),
    .full    (q_full),
    .pop     (q_pop),
    .empty   (q_empty),
    .head_op (head_op)
  );

  vefc_back #(
    .FRACTION_BITS (FRACTION_BITS)
  ) u_back (
    .clk               (clk),
    .rst_n             (rst_n),
    .reset_value       (reset_value_r),
    .sample_rate       (sample_rate_r),
    .op_empty          (q_empty),
    .op                (head_op),
    .op_pop            (q_pop),
    .out_valid         (out_tvalid),
    .out_ready         (out_tready),
    .out_counter       (out_tdata),
    .out_counter_valid (out_tuser)
  );

endmodule
